// ===== rtl/core/bimr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bimr_pkg;

    localparam int RATE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 8;
    localparam int STORED_W = 3;
    localparam int DIV_CNT_W = 4;

    localparam logic [RATE_W-1:0]    RATE_DIVIDEND   = 16'd60000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP   = 4'd15;
    localparam logic [LIMIT_W-1:0]   LOW_LIMIT_RESET  = 8'd20;
    localparam logic [LIMIT_W-1:0]   HIGH_LIMIT_RESET = 8'd255;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_LOW_LIMIT  = 1'b0,
        REG_HIGH_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_READ_CAND,
        ST_TAKE_CAND,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start_div;
        logic div_step;
        logic check;
        logic read_cand;
        logic take_cand;
        logic scan;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rate_ok;
        logic scan_last;
        logic is_median;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bimr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bimr_ctrl
    import bimr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.rate_ok ? ST_READ_CAND : ST_OUT;
            end
            ST_READ_CAND: state_next = ST_TAKE_CAND;
            ST_TAKE_CAND: state_next = ST_SCAN;
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = status.is_median ? ST_OUT : ST_READ_CAND;
                end
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.start_div = s_tvalid;
            end
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_CHECK:     cmd.check     = 1'b1;
            ST_READ_CAND: cmd.read_cand = 1'b1;
            ST_TAKE_CAND: cmd.take_cand = 1'b1;
            ST_SCAN:      cmd.scan      = 1'b1;
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bimr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bimr_dp
    import bimr_pkg::*;
#(
    parameter int RATE_DEPTH = 6
)
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    input  wire logic [TIME_W-1:0]  beat_time_ms,
    input  wire logic [LIMIT_W-1:0] low_limit,
    input  wire logic [LIMIT_W-1:0] high_limit,
    output logic [RATE_W-1:0]       instant_rate,
    output logic                    rate_accepted,
    output logic [LIMIT_W-1:0]      median_rate,
    output logic [STORED_W-1:0]     rates_stored
);

    localparam int IDX_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
    localparam int CNT_W = $clog2(RATE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(RATE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RATE_DEPTH);

    // beat interval and serial divider
    logic [TIME_W-1:0]    prev_time_reg;
    logic [TIME_W-1:0]    delta_reg;
    logic [RATE_W-1:0]    quot_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [RATE_W:0]      rem_shift;
    logic [RATE_W:0]      rem_diff;
    logic                 rem_ge;
    logic                 delta_zero;
    logic [RATE_W-1:0]    rate;
    logic                 rate_ok;

    assign rem_shift  = {rem_reg, quot_reg[RATE_W-1]};
    assign rem_ge     = {{(TIME_W-RATE_W-1){1'b0}}, rem_shift} >= delta_reg;
    assign rem_diff   = rem_shift - delta_reg[RATE_W:0];
    assign delta_zero = (delta_reg == '0);
    assign rate       = delta_zero ? RATE_DIVIDEND : quot_reg;
    assign rate_ok    = (rate < {8'd0, high_limit}) && (rate > {8'd0, low_limit});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
        end else if (cmd.start_div) begin
            prev_time_reg <= beat_time_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            delta_reg   <= beat_time_ms - prev_time_reg;
            quot_reg    <= RATE_DIVIDEND;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_ge ? rem_diff[RATE_W-1:0] : rem_shift[RATE_W-1:0];
            quot_reg    <= {quot_reg[RATE_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // rate ring and bookkeeping
    logic [LIMIT_W-1:0] ring_mem [RATE_DEPTH];
    logic [IDX_W-1:0]   wpos_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LIMIT_W-1:0] median_reg;
    logic               ring_wr;

    assign ring_wr = cmd.check && rate_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg   <= '0;
            count_reg  <= '0;
        end else if (ring_wr) begin
            wpos_reg <= (wpos_reg == LAST_POS) ? '0 : wpos_reg + 1'b1;
            if (count_reg < DEPTH_CNT) count_reg <= count_reg + 1'b1;
        end
    end

    // median by rank: entry i is the answer when exactly count/2 entries
    // sort ahead of it (ties broken by index)
    logic [IDX_W-1:0]   cand_idx_reg;
    logic [LIMIT_W-1:0] cand_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   rank_reg;
    logic [LIMIT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic               sorts_ahead;
    logic [CNT_W-1:0]   rank_sum;

    assign rd_addr = cmd.read_cand ? cand_idx_reg : scan_idx_reg[IDX_W-1:0];
    assign rd_en   = cmd.read_cand ||
                     ((cmd.take_cand || cmd.scan) && (scan_idx_reg < count_reg));

    always_ff @(posedge aclk) begin
        if (ring_wr) ring_mem[wpos_reg] <= rate[LIMIT_W-1:0];
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    assign sorts_ahead = (rd_data_reg < cand_reg) ||
                         ((rd_data_reg == cand_reg) && (rd_idx_reg < cand_idx_reg));
    assign rank_sum    = rank_reg + CNT_W'(sorts_ahead);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            median_reg <= '0;
        end else if (cmd.scan && status.scan_last && status.is_median) begin
            median_reg <= cand_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            cand_idx_reg <= '0;
        end
        if (cmd.read_cand) begin
            scan_idx_reg <= '0;
        end
        if (cmd.take_cand) begin
            cand_reg     <= rd_data_reg;
            rank_reg     <= '0;
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        if (cmd.scan) begin
            rank_reg <= rank_sum;
            if (rd_en) scan_idx_reg <= scan_idx_reg + 1'b1;
            if (status.scan_last) cand_idx_reg <= cand_idx_reg + 1'b1;
        end
    end

    assign status.div_done  = (div_cnt_reg == DIV_LAST_STEP);
    assign status.rate_ok   = rate_ok;
    assign status.scan_last = ({1'b0, rd_idx_reg} == {1'b0, count_reg[IDX_W-1:0]} - 1'b1)
                              || (CNT_W'(rd_idx_reg) == count_reg - 1'b1);
    assign status.is_median = (rank_sum == (count_reg >> 1));

    // result register
    logic [RATE_W-1:0]   out_rate_reg;
    logic                out_acc_reg;
    logic [LIMIT_W-1:0]  out_median_reg;
    logic [STORED_W-1:0] out_stored_reg;
    logic                acc_reg;
    logic [4:0]          count_wide;

    assign count_wide = 5'(count_reg);

    // hold the accept flag until the result register is free
    always_ff @(posedge aclk) begin
        if (cmd.check) acc_reg <= rate_ok;
        if (cmd.load_out) begin
            out_rate_reg   <= rate;
            out_acc_reg    <= acc_reg;
            out_median_reg <= median_reg;
            out_stored_reg <= count_wide[STORED_W-1:0];
        end
    end

    assign instant_rate  = out_rate_reg;
    assign rate_accepted = out_acc_reg;
    assign median_rate   = out_median_reg;
    assign rates_stored  = out_stored_reg;

endmodule

`default_nettype wire

// ===== rtl/core/beat_interval_median_rate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                       Carries
// s_        s_tvalid/s_tready/s_tdata   beat_time_ms
// m_        m_tvalid/m_tready/m_tdata   instant_rate, rate_accepted, median_rate, rates_stored
// apb       psel/penable/pwrite/paddr   rate_low_limit (0x0), rate_high_limit (0x4)
//
// Each beat passes through the interval and the bit-serial 60000/interval divider, then,
// for an accepted rate, the rank search over the n stored rates (one ring read per
// cycle), then a load of the result register. aresetn is synchronous: limits return
// to 20 and 255, count, ring pointer, last beat time and median to zero. A held result
// does not stop the next beat from being taken; the result register waits for m_tready.
module beat_interval_median_rate
    import bimr_pkg::*;
#(
    parameter int RATE_DEPTH = 6
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] beat_time_ms
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] instant_rate, [16] rate_accepted,
                                        // [24:17] median_rate, [27:25] rates_stored
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [LIMIT_W-1:0] low_limit_reg;
    logic [LIMIT_W-1:0] high_limit_reg;
    logic               cfg_wr;
    reg_index_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= LOW_LIMIT_RESET;
            high_limit_reg <= HIGH_LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LOW_LIMIT:  low_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_HIGH_LIMIT: high_limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LOW_LIMIT:  prdata = {24'd0, low_limit_reg};
            REG_HIGH_LIMIT: prdata = {24'd0, high_limit_reg};
            default:        prdata = '0;
        endcase
    end

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [RATE_W-1:0]   instant_rate;
    logic                rate_accepted;
    logic [LIMIT_W-1:0]  median_rate;
    logic [STORED_W-1:0] rates_stored;

    bimr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bimr_dp #(
        .RATE_DEPTH (RATE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .beat_time_ms  (s_tdata),
        .low_limit     (low_limit_reg),
        .high_limit    (high_limit_reg),
        .instant_rate  (instant_rate),
        .rate_accepted (rate_accepted),
        .median_rate   (median_rate),
        .rates_stored  (rates_stored)
    );

    assign m_tdata = {4'd0, rates_stored, median_rate, rate_accepted, instant_rate};

endmodule

`default_nettype wire
